// ===== hdl/ptal_pkg.sv =====
// ptal_pkg: shared types, constants and functions of the pan/tilt aim limiter
package ptal_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_N       = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int STEP_W       = (STEP_N > 1) ? $clog2(STEP_N) : 1;

    localparam int CW    = 40;
    localparam int ACC_W = 24;

    localparam logic signed [33:0]      PIVOT_HEIGHT = 34'sd39322;
    localparam logic signed [ACC_W-1:0] HALF_PI_Q20  = 24'sd1647099;

    localparam logic [1:0] MODE_YAW_ADD   = 2'd0;
    localparam logic [1:0] MODE_PITCH_ADD = 2'd1;
    localparam logic [1:0] MODE_SET       = 2'd2;
    localparam logic [1:0] MODE_AIM       = 2'd3;

    localparam logic [2:0] REG_BASE_X      = 3'd0;
    localparam logic [2:0] REG_BASE_Y      = 3'd1;
    localparam logic [2:0] REG_BASE_Z      = 3'd2;
    localparam logic [2:0] REG_YAW_LOWER   = 3'd3;
    localparam logic [2:0] REG_YAW_UPPER   = 3'd4;
    localparam logic [2:0] REG_PITCH_LOWER = 3'd5;
    localparam logic [2:0] REG_PITCH_UPPER = 3'd6;

    localparam logic signed [15:0] YAW_LOWER_RST   = -16'sd8579;
    localparam logic signed [15:0] YAW_UPPER_RST   = 16'sd8579;
    localparam logic signed [15:0] PITCH_LOWER_RST = -16'sd4289;
    localparam logic signed [15:0] PITCH_UPPER_RST = 16'sd4289;

    typedef struct packed {
        logic signed [31:0] base_x;
        logic signed [31:0] base_y;
        logic signed [31:0] base_z;
        logic signed [15:0] yaw_lower;
        logic signed [15:0] yaw_upper;
        logic signed [15:0] pitch_lower;
        logic signed [15:0] pitch_upper;
    } cfg_t;

    typedef struct packed {
        logic                 start;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } cordic_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [ACC_W-1:0] angle;
        logic signed [CW-1:0]    mag;
    } cordic_rsp_t;

    // cordic gain in q.24, evaluated at elaboration
    function automatic logic [63:0] gain_q24_calc();
        logic [63:0] k2;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        k2 = 64'd1 << 48;
        for (int i = 0; i < STEP_N; i++) begin
            k2 = k2 + (k2 >> (2 * i));
        end
        n = k2;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    localparam logic signed [25:0] GAIN_Q24 = 26'(gain_q24_calc());

    function automatic logic signed [ACC_W-1:0] atan_q20(input logic [4:0] idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            5'd0:    v = 24'sd823550;
            5'd1:    v = 24'sd486170;
            5'd2:    v = 24'sd256879;
            5'd3:    v = 24'sd130396;
            5'd4:    v = 24'sd65451;
            5'd5:    v = 24'sd32757;
            5'd6:    v = 24'sd16383;
            5'd7:    v = 24'sd8192;
            5'd8:    v = 24'sd4096;
            5'd9:    v = 24'sd2048;
            5'd10:   v = 24'sd1024;
            5'd11:   v = 24'sd512;
            5'd12:   v = 24'sd256;
            5'd13:   v = 24'sd128;
            5'd14:   v = 24'sd64;
            5'd15:   v = 24'sd32;
            5'd16:   v = 24'sd16;
            5'd17:   v = 24'sd8;
            5'd18:   v = 24'sd4;
            5'd19:   v = 24'sd2;
            5'd20:   v = 24'sd1;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

    // q.20 to q.13 with halves rounded up
    function automatic logic signed [16:0] to_q13(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W:0] t;
        t = {a[ACC_W-1], a} + 25'sd64;
        return t[ACC_W-1:7];
    endfunction

    // lower test first, upper test second
    function automatic logic signed [15:0] clamp_lim(input logic signed [16:0] v,
                                                     input logic signed [15:0] lo,
                                                     input logic signed [15:0] hi);
        logic signed [16:0] r;
        r = v;
        if (r < $signed({lo[15], lo})) begin
            r = $signed({lo[15], lo});
        end
        if (r > $signed({hi[15], hi})) begin
            r = $signed({hi[15], hi});
        end
        return r[15:0];
    endfunction

endpackage

// ===== hdl/ptal_if.sv =====
// ptal_if: command and result channel interfaces
interface ptal_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [15:0] yaw_value;
    logic signed [15:0] pitch_value;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;

    modport source (
        output valid, mode, yaw_value, pitch_value, target_x, target_y, target_z,
        input  ready
    );
    modport sink (
        input  valid, mode, yaw_value, pitch_value, target_x, target_y, target_z,
        output ready
    );
endinterface

interface ptal_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;

    modport source (
        output valid, yaw_angle, pitch_angle,
        input  ready
    );
    modport sink (
        input  valid, yaw_angle, pitch_angle,
        output ready
    );
endinterface

// ===== hdl/ptal_regs.sv =====
// ptal_regs: apb configuration registers for base position and angle limits
module ptal_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output ptal_pkg::cfg_t cfg
);
    import ptal_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.base_x      <= '0;
            cfg_reg.base_y      <= '0;
            cfg_reg.base_z      <= '0;
            cfg_reg.yaw_lower   <= YAW_LOWER_RST;
            cfg_reg.yaw_upper   <= YAW_UPPER_RST;
            cfg_reg.pitch_lower <= PITCH_LOWER_RST;
            cfg_reg.pitch_upper <= PITCH_UPPER_RST;
        end
        else if (wr_en) begin
            case (idx)
                REG_BASE_X:      cfg_reg.base_x      <= pwdata;
                REG_BASE_Y:      cfg_reg.base_y      <= pwdata;
                REG_BASE_Z:      cfg_reg.base_z      <= pwdata;
                REG_YAW_LOWER:   cfg_reg.yaw_lower   <= pwdata[15:0];
                REG_YAW_UPPER:   cfg_reg.yaw_upper   <= pwdata[15:0];
                REG_PITCH_LOWER: cfg_reg.pitch_lower <= pwdata[15:0];
                REG_PITCH_UPPER: cfg_reg.pitch_upper <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_BASE_X:      prdata = cfg_reg.base_x;
            REG_BASE_Y:      prdata = cfg_reg.base_y;
            REG_BASE_Z:      prdata = cfg_reg.base_z;
            REG_YAW_LOWER:   prdata = {{16{cfg_reg.yaw_lower[15]}}, cfg_reg.yaw_lower};
            REG_YAW_UPPER:   prdata = {{16{cfg_reg.yaw_upper[15]}}, cfg_reg.yaw_upper};
            REG_PITCH_LOWER: prdata = {{16{cfg_reg.pitch_lower[15]}}, cfg_reg.pitch_lower};
            REG_PITCH_UPPER: prdata = {{16{cfg_reg.pitch_upper[15]}}, cfg_reg.pitch_upper};
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== hdl/ptal_cordic.sv =====
// ptal_cordic: iterative cordic vectoring unit, one micro-rotation per cycle
module ptal_cordic (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptal_pkg::cordic_req_t req,
    output ptal_pkg::cordic_rsp_t rsp
);
    import ptal_pkg::*;

    typedef enum logic {
        C_IDLE,
        C_RUN
    } cstate_t;

    cstate_t                 state_reg, state_next;
    logic [STEP_W-1:0]       cnt_reg, cnt_next;
    logic signed [CW-1:0]    x_reg, x_next;
    logic signed [CW-1:0]    y_reg, y_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    done_reg, done_next;
    logic signed [CW-1:0]    xs;
    logic signed [CW-1:0]    ys;
    logic signed [ACC_W-1:0] step_atan;
    logic                    y_pos;

    assign xs        = x_reg >>> cnt_reg;
    assign ys        = y_reg >>> cnt_reg;
    assign step_atan = atan_q20(5'(cnt_reg));
    assign y_pos     = !y_reg[CW-1] && (y_reg != '0);

    assign rsp.done  = done_reg;
    assign rsp.angle = acc_reg;
    assign rsp.mag   = x_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        case (state_reg)
            C_IDLE: begin
                if (req.start) begin
                    cnt_next = '0;
                    if (req.x == '0 && req.y == '0) begin
                        x_next    = '0;
                        y_next    = '0;
                        acc_next  = '0;
                        done_next = 1'b1;
                    end
                    else begin
                        state_next = C_RUN;
                        if (req.x[CW-1]) begin
                            if (!req.y[CW-1] && req.y != '0) begin
                                x_next   = req.y;
                                y_next   = -req.x;
                                acc_next = HALF_PI_Q20;
                            end
                            else begin
                                x_next   = -req.y;
                                y_next   = req.x;
                                acc_next = -HALF_PI_Q20;
                            end
                        end
                        else begin
                            x_next   = req.x;
                            y_next   = req.y;
                            acc_next = '0;
                        end
                    end
                end
            end
            C_RUN: begin
                if (y_pos) begin
                    x_next   = x_reg + ys;
                    y_next   = y_reg - xs;
                    acc_next = acc_reg + step_atan;
                end
                else begin
                    x_next   = x_reg - ys;
                    y_next   = y_reg + xs;
                    acc_next = acc_reg - step_atan;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(STEP_N - 1)) begin
                    state_next = C_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            acc_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            acc_reg   <= acc_next;
            done_reg  <= done_next;
        end
    end

endmodule

// ===== hdl/ptal_seq.sv =====
// ptal_seq: command sequencer, gain multiply, angle state and result register
module ptal_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    ptal_cmd_if.sink              cmd,
    ptal_res_if.source            res,
    input  ptal_pkg::cfg_t        cfg,
    output ptal_pkg::cordic_req_t creq,
    input  ptal_pkg::cordic_rsp_t crsp
);
    import ptal_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_MUL_LO,
        S_MUL_HI,
        S_YAW_GO,
        S_YAW_RUN,
        S_PITCH_GO,
        S_PITCH_RUN,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic signed [32:0] dx_reg, dx_next;
    logic signed [32:0] dy_reg, dy_next;
    logic signed [33:0] dz_reg, dz_next;
    logic signed [59:0] prod_reg, prod_next;
    logic signed [16:0] yaw_raw_reg, yaw_raw_next;
    logic signed [16:0] pitch_raw_reg, pitch_raw_next;
    logic               upd_yaw_reg, upd_yaw_next;
    logic               upd_pitch_reg, upd_pitch_next;
    logic signed [15:0] yaw_now_reg, yaw_now_next;
    logic signed [15:0] pitch_now_reg, pitch_now_next;
    logic               res_valid_reg, res_valid_next;
    logic signed [15:0] res_yaw_reg, res_yaw_next;
    logic signed [15:0] res_pitch_reg, res_pitch_next;

    logic signed [17:0] mul_a;
    logic signed [43:0] mul_p;
    logic signed [59:0] mul_ext;
    logic signed [15:0] yaw_fin;
    logic signed [15:0] pitch_fin;
    logic               out_free;

    assign cmd.ready       = (state_reg == S_IDLE);
    assign res.valid       = res_valid_reg;
    assign res.yaw_angle   = res_yaw_reg;
    assign res.pitch_angle = res_pitch_reg;

    assign out_free = !res_valid_reg || res.ready;

    // dz times gain as two 17-bit partial products
    always_comb begin
        if (state_reg == S_MUL_HI) begin
            mul_a = $signed({dz_reg[33], dz_reg[33:17]});
        end
        else begin
            mul_a = $signed({1'b0, dz_reg[16:0]});
        end
    end
    assign mul_p   = mul_a * GAIN_Q24;
    assign mul_ext = {{16{mul_p[43]}}, mul_p};

    assign yaw_fin   = upd_yaw_reg ? clamp_lim(yaw_raw_reg, cfg.yaw_lower, cfg.yaw_upper)
                                   : yaw_now_reg;
    assign pitch_fin = upd_pitch_reg ? clamp_lim(pitch_raw_reg, cfg.pitch_lower,
                                                 cfg.pitch_upper)
                                     : pitch_now_reg;

    always_comb begin
        creq.start = 1'b0;
        creq.x     = '0;
        creq.y     = '0;
        case (state_reg)
            S_YAW_GO: begin
                creq.start = 1'b1;
                creq.x     = {{(CW-33){dy_reg[32]}}, dy_reg};
                creq.y     = -{{(CW-33){dx_reg[32]}}, dx_reg};
            end
            S_PITCH_GO: begin
                creq.start = 1'b1;
                creq.x     = crsp.mag;
                creq.y     = {{(CW-36){prod_reg[59]}}, prod_reg[59:24]};
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dz_next        = dz_reg;
        prod_next      = prod_reg;
        yaw_raw_next   = yaw_raw_reg;
        pitch_raw_next = pitch_raw_reg;
        upd_yaw_next   = upd_yaw_reg;
        upd_pitch_next = upd_pitch_reg;
        yaw_now_next   = yaw_now_reg;
        pitch_now_next = pitch_now_reg;
        res_valid_next = res_valid_reg;
        res_yaw_next   = res_yaw_reg;
        res_pitch_next = res_pitch_reg;

        if (res_valid_reg && res.ready) begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (cmd.valid) begin
                    upd_yaw_next   = 1'b0;
                    upd_pitch_next = 1'b0;
                    case (cmd.mode)
                        MODE_YAW_ADD: begin
                            upd_yaw_next = 1'b1;
                            yaw_raw_next = $signed({yaw_now_reg[15], yaw_now_reg})
                                         + $signed({cmd.yaw_value[15], cmd.yaw_value});
                            state_next   = S_DONE;
                        end
                        MODE_PITCH_ADD: begin
                            upd_pitch_next = 1'b1;
                            pitch_raw_next = $signed({pitch_now_reg[15], pitch_now_reg})
                                           + $signed({cmd.pitch_value[15], cmd.pitch_value});
                            state_next     = S_DONE;
                        end
                        MODE_SET: begin
                            upd_yaw_next   = 1'b1;
                            upd_pitch_next = 1'b1;
                            yaw_raw_next   = $signed({cmd.yaw_value[15], cmd.yaw_value});
                            pitch_raw_next = $signed({cmd.pitch_value[15], cmd.pitch_value});
                            state_next     = S_DONE;
                        end
                        MODE_AIM: begin
                            upd_yaw_next   = 1'b1;
                            upd_pitch_next = 1'b1;
                            dx_next = $signed({cmd.target_x[31], cmd.target_x})
                                    - $signed({cfg.base_x[31], cfg.base_x});
                            dy_next = $signed({cmd.target_y[31], cmd.target_y})
                                    - $signed({cfg.base_y[31], cfg.base_y});
                            dz_next = $signed({{2{cmd.target_z[31]}}, cmd.target_z})
                                    - $signed({{2{cfg.base_z[31]}}, cfg.base_z});
                            state_next = S_DIFF;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIFF: begin
                dz_next    = dz_reg - PIVOT_HEIGHT;
                state_next = S_MUL_LO;
            end
            S_MUL_LO: begin
                prod_next  = mul_ext;
                state_next = S_MUL_HI;
            end
            S_MUL_HI: begin
                prod_next  = prod_reg + (mul_ext <<< 17);
                state_next = S_YAW_GO;
            end
            S_YAW_GO: begin
                state_next = S_YAW_RUN;
            end
            S_YAW_RUN: begin
                if (crsp.done) begin
                    yaw_raw_next = to_q13(crsp.angle);
                    state_next   = S_PITCH_GO;
                end
            end
            S_PITCH_GO: begin
                state_next = S_PITCH_RUN;
            end
            S_PITCH_RUN: begin
                if (crsp.done) begin
                    pitch_raw_next = to_q13(crsp.angle);
                    state_next     = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    yaw_now_next   = yaw_fin;
                    pitch_now_next = pitch_fin;
                    res_yaw_next   = yaw_fin;
                    res_pitch_next = pitch_fin;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            dx_reg        <= '0;
            dy_reg        <= '0;
            dz_reg        <= '0;
            prod_reg      <= '0;
            yaw_raw_reg   <= '0;
            pitch_raw_reg <= '0;
            upd_yaw_reg   <= 1'b0;
            upd_pitch_reg <= 1'b0;
            yaw_now_reg   <= '0;
            pitch_now_reg <= '0;
            res_valid_reg <= 1'b0;
            res_yaw_reg   <= '0;
            res_pitch_reg <= '0;
        end
        else begin
            state_reg     <= state_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            dz_reg        <= dz_next;
            prod_reg      <= prod_next;
            yaw_raw_reg   <= yaw_raw_next;
            pitch_raw_reg <= pitch_raw_next;
            upd_yaw_reg   <= upd_yaw_next;
            upd_pitch_reg <= upd_pitch_next;
            yaw_now_reg   <= yaw_now_next;
            pitch_now_reg <= pitch_now_next;
            res_valid_reg <= res_valid_next;
            res_yaw_reg   <= res_yaw_next;
            res_pitch_reg <= res_pitch_next;
        end
    end

endmodule

// ===== hdl/pan_tilt_aim_limiter.sv =====
// pan_tilt_aim_limiter: pan/tilt angle keeper with target aiming and limit clamping
// delta and set requests: go straight to the done state, which loads the result once the output is free
// aim requests: pivot offset, two multiply halves, then two sequential passes through
//   the one cordic unit, one micro-rotation per cycle, fewer on a zero vector, then done
// one request in flight; the next can be taken in the cycle the result is first shown
// reset: rst_n clears angles to zero, base to zero and limits to +-60 / +-30 degrees
module pan_tilt_aim_limiter (
    input  logic        clk,
    input  logic        rst_n,
    ptal_cmd_if.sink    cmd,
    ptal_res_if.source  res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ptal_pkg::*;

    cfg_t        cfg;
    cordic_req_t creq;
    cordic_rsp_t crsp;

    ptal_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ptal_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rsp   (crsp)
    );

    ptal_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res),
        .cfg   (cfg),
        .creq  (creq),
        .crsp  (crsp)
    );

endmodule

// ===== hdl/ptal_checker.sv =====
// ptal_checker: port-level assertions for the pan/tilt aim limiter, bound to the top
module ptal_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [15:0] yaw_angle,
    input logic [15:0] pitch_angle
);

    // one request in flight: not ready right after taking one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("ready right after a request was taken");

    // no result appears in the cycle right after a request is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !$rose(res_valid))
        else $error("result appeared too early");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped before taken");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(yaw_angle) && $stable(pitch_angle))
        else $error("result changed while stalled");

endmodule

bind pan_tilt_aim_limiter ptal_checker u_ptal_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .yaw_angle   (res.yaw_angle),
    .pitch_angle (res.pitch_angle)
);

// ===== bench/pan_tilt_aim_limiter_tb.sv =====
// pan_tilt_aim_limiter_tb: self-checking bench for the pan/tilt aim limiter
`timescale 1ns / 1ps

module pan_tilt_aim_limiter_tb;
    import ptal_pkg::*;

    localparam int       QUIET_LIMIT = 3000;
    localparam int       PHASE_ITEMS = 110;
    localparam longint   HALF_PI     = 64'sd1647099;
    localparam longint   PIVOT_Q16   = 64'sd39322;

    typedef struct {
        logic [1:0]         mode;
        logic signed [15:0] yaw_value;
        logic signed [15:0] pitch_value;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
    } aim_cmd_t;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
    } angle_pair_t;

    typedef struct {
        bit          is_reg;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        aim_cmd_t    c;
        bit          typed;
        angle_pair_t fixed;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ptal_cmd_if cmd_ch ();
    ptal_res_if res_ch ();

    pan_tilt_aim_limiter i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mount model state
    int     base_x      = 0;
    int     base_y      = 0;
    int     base_z      = 0;
    int     yaw_lo      = -8579;
    int     yaw_hi      = 8579;
    int     pitch_lo    = -4289;
    int     pitch_hi    = 4289;
    int     yaw_pos     = 0;
    int     pitch_pos   = 0;
    longint mount_gain;
    longint atan_tab [24] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0, 0, 0
    };

    angle_pair_t pending_angles [$];
    dir_row_t    dir_tab [$];
    int          fail_count    = 0;
    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;
    int          hold_cycles   = 0;
    int          held          = 0;
    int          quiet         = 0;

    function automatic longint gain_q24_of_steps();
        longint unsigned k2;
        longint unsigned r;
        longint unsigned trial;
        int              i;
        int              b;
        k2 = 64'd1 << 48;
        for (i = 0; i < STEP_N; i++)
        begin
            k2 = k2 + (k2 >> (2 * i));
        end
        r = 0;
        for (b = 31; b >= 0; b--)
        begin
            trial = r | (64'd1 << b);
            if (trial * trial <= k2)
            begin
                r = trial;
            end
        end
        return longint'(r);
    endfunction

    function automatic longint cordic_vector(input longint x0, input longint y0,
                                             output longint mag);
        longint x;
        longint y;
        longint t;
        longint acc;
        longint xs;
        longint ys;
        int     i;
        x   = x0;
        y   = y0;
        acc = 0;
        mag = 0;
        if (x == 0 && y == 0)
        begin
            return 0;
        end
        if (x < 0)
        begin
            t = x;
            if (y > 0)
            begin
                x   = y;
                y   = -t;
                acc = HALF_PI;
            end
            else
            begin
                x   = -y;
                y   = t;
                acc = -HALF_PI;
            end
        end
        for (i = 0; i < STEP_N; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x   = x + ys;
                y   = y - xs;
                acc = acc + atan_tab[i];
            end
            else
            begin
                x   = x - ys;
                y   = y + xs;
                acc = acc - atan_tab[i];
            end
        end
        mag = x;
        return acc;
    endfunction

    function automatic int round_q13(input longint a);
        return int'((a + 64) >>> 7);
    endfunction

    // lower bound first, so inverted limits settle on the upper one
    function automatic int clamp_angle(input int v, input int lo, input int hi);
        int r;
        r = v;
        if (r < lo)
        begin
            r = lo;
        end
        if (r > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    function automatic angle_pair_t advance_mount(input aim_cmd_t c);
        longint      dx;
        longint      dy;
        longint      dz;
        longint      range_k;
        longint      unused_mag;
        longint      zk;
        longint      yaw_a;
        longint      pitch_a;
        angle_pair_t r;
        case (c.mode)
            MODE_YAW_ADD:
            begin
                yaw_pos = clamp_angle(yaw_pos + int'(c.yaw_value), yaw_lo, yaw_hi);
            end
            MODE_PITCH_ADD:
            begin
                pitch_pos = clamp_angle(pitch_pos + int'(c.pitch_value), pitch_lo, pitch_hi);
            end
            MODE_SET:
            begin
                yaw_pos   = clamp_angle(int'(c.yaw_value), yaw_lo, yaw_hi);
                pitch_pos = clamp_angle(int'(c.pitch_value), pitch_lo, pitch_hi);
            end
            default:
            begin
                dx        = longint'(c.target_x) - longint'(base_x);
                dy        = longint'(c.target_y) - longint'(base_y);
                dz        = longint'(c.target_z) - longint'(base_z) - PIVOT_Q16;
                yaw_a     = cordic_vector(dy, -dx, range_k);
                zk        = (dz * mount_gain) >>> 24;
                pitch_a   = cordic_vector(range_k, zk, unused_mag);
                yaw_pos   = clamp_angle(round_q13(yaw_a), yaw_lo, yaw_hi);
                pitch_pos = clamp_angle(round_q13(pitch_a), pitch_lo, pitch_hi);
            end
        endcase
        r.yaw   = 16'(yaw_pos);
        r.pitch = 16'(pitch_pos);
        return r;
    endfunction

    function automatic dir_row_t cmd_row(input logic [1:0] m, input int yv, input int pv,
                                         input logic [31:0] tx, input logic [31:0] ty,
                                         input logic [31:0] tz, input bit typed,
                                         input int ey, input int ep);
        dir_row_t r;
        r.is_reg        = 1'b0;
        r.reg_idx       = REG_BASE_X;
        r.reg_val       = '0;
        r.c.mode        = m;
        r.c.yaw_value   = 16'(yv);
        r.c.pitch_value = 16'(pv);
        r.c.target_x    = tx;
        r.c.target_y    = ty;
        r.c.target_z    = tz;
        r.typed         = typed;
        r.fixed.yaw     = 16'(ey);
        r.fixed.pitch   = 16'(ep);
        return r;
    endfunction

    function automatic dir_row_t reg_row(input logic [2:0] idx, input logic [31:0] val);
        dir_row_t r;
        r         = cmd_row(MODE_SET, 0, 0, '0, '0, '0, 1'b0, 0, 0);
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1, 2:    return 16'(int'($urandom_range(4000)) - 2000);
            default: return 16'(int'($urandom_range(51472)) - 25736);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coord(input logic signed [31:0] ctr);
        int sh;
        if ($urandom_range(3) == 0)
        begin
            return $urandom;
        end
        sh = $urandom_range(4, 26);
        return ctr + ($signed($urandom) >>> (31 - sh));
    endfunction

    function automatic aim_cmd_t rand_cmd();
        aim_cmd_t c;
        c.mode        = 2'($urandom_range(3));
        c.yaw_value   = rand_angle();
        c.pitch_value = rand_angle();
        c.target_x    = rand_coord(base_x);
        c.target_y    = rand_coord(base_y);
        c.target_z    = rand_coord(base_z + int'(PIVOT_Q16));
        return c;
    endfunction

    task automatic push_cmd(input aim_cmd_t c, input bit typed, input angle_pair_t fixed);
        angle_pair_t nxt;
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.mode        <= c.mode;
        cmd_ch.yaw_value   <= c.yaw_value;
        cmd_ch.pitch_value <= c.pitch_value;
        cmd_ch.target_x    <= c.target_x;
        cmd_ch.target_y    <= c.target_y;
        cmd_ch.target_z    <= c.target_z;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        nxt = advance_mount(c);
        pending_angles.push_back(typed ? fixed : nxt);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (pending_angles.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        bit wide;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        wide = 1'b0;
        case (idx)
            REG_BASE_X:
            begin
                base_x = int'(val);
                wide   = 1'b1;
            end
            REG_BASE_Y:
            begin
                base_y = int'(val);
                wide   = 1'b1;
            end
            REG_BASE_Z:
            begin
                base_z = int'(val);
                wide   = 1'b1;
            end
            REG_YAW_LOWER:   yaw_lo   = int'($signed(val[15:0]));
            REG_YAW_UPPER:   yaw_hi   = int'($signed(val[15:0]));
            REG_PITCH_LOWER: pitch_lo = int'($signed(val[15:0]));
            REG_PITCH_UPPER: pitch_hi = int'($signed(val[15:0]));
            default:         wide     = 1'b1;
        endcase
        if (wide ? (prdata !== val) : (prdata[15:0] !== val[15:0]))
        begin
            $display("%0t: register %0d readback expected %h actual %h",
                     $time, idx, val, prdata);
            fail_count++;
        end
    endtask

    // receiver side, with a one-off long hold-off
    initial
    begin
        res_ch.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        if (held < hold_cycles)
        begin
            res_ch.ready <= 1'b0;
            held++;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_res
        angle_pair_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_angles.size() == 0)
            begin
                $display("%0t: unexpected result yaw %0d pitch %0d",
                         $time, res_ch.yaw_angle, res_ch.pitch_angle);
                fail_count++;
            end
            else
            begin
                want = pending_angles.pop_front();
                if (res_ch.yaw_angle !== want.yaw)
                begin
                    $display("%0t: yaw_angle expected %0d actual %0d",
                             $time, want.yaw, res_ch.yaw_angle);
                    fail_count++;
                end
                if (res_ch.pitch_angle !== want.pitch)
                begin
                    $display("%0t: pitch_angle expected %0d actual %0d",
                             $time, want.pitch, res_ch.pitch_angle);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
        begin
            quiet <= 0;
        end
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: no request or result moved for %0d cycles", $time, quiet);
            $display("tb: failure");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    initial
    begin : stimulus
        int          ph;
        int          a;
        int          b;
        int          t;
        logic [31:0] bx;
        logic [31:0] by;
        logic [31:0] bz;
        logic [31:0] ylo;
        logic [31:0] yhi;
        logic [31:0] plo;
        logic [31:0] phi;

        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.mode        = MODE_YAW_ADD;
        cmd_ch.yaw_value   = '0;
        cmd_ch.pitch_value = '0;
        cmd_ch.target_x    = '0;
        cmd_ch.target_y    = '0;
        cmd_ch.target_z    = '0;
        mount_gain         = gain_q24_of_steps();

        dir_tab.push_back(cmd_row(MODE_SET, 0, 0, '0, '0, '0, 1'b1, 0, 0));
        dir_tab.push_back(cmd_row(MODE_YAW_ADD, 32767, 0, '0, '0, '0, 1'b1, 8579, 0));
        dir_tab.push_back(cmd_row(MODE_YAW_ADD, -32768, 0, '0, '0, '0, 1'b1, -8579, 0));
        dir_tab.push_back(cmd_row(MODE_PITCH_ADD, 0, 32767, '0, '0, '0, 1'b1, -8579, 4289));
        dir_tab.push_back(cmd_row(MODE_PITCH_ADD, 0, -32768, '0, '0, '0, 1'b1, -8579, -4289));
        dir_tab.push_back(cmd_row(MODE_SET, 25736, -25736, '0, '0, '0, 1'b1, 8579, -4289));
        dir_tab.push_back(cmd_row(MODE_SET, -25736, 25736, '0, '0, '0, 1'b1, -8579, 4289));
        // target at the origin, straight below the pivot
        dir_tab.push_back(cmd_row(MODE_AIM, 0, 0, '0, '0, '0, 1'b1, 0, -4289));
        // target straight behind
        dir_tab.push_back(cmd_row(MODE_AIM, 0, 0, 32'h0, 32'hFFFF0000, 32'h0000999A,
                                  1'b0, 0, 0));
        dir_tab.push_back(cmd_row(MODE_AIM, 0, 0, 32'h00030000, 32'h00040000, 32'h00020000,
                                  1'b0, 0, 0));
        dir_tab.push_back(cmd_row(MODE_AIM, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                  1'b0, 0, 0));
        dir_tab.push_back(cmd_row(MODE_AIM, 0, 0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                  1'b0, 0, 0));
        dir_tab.push_back(reg_row(REG_YAW_LOWER, 32'hFFFF8000));
        dir_tab.push_back(reg_row(REG_YAW_UPPER, 32'h00007FFF));
        dir_tab.push_back(reg_row(REG_PITCH_LOWER, 32'hFFFF8000));
        dir_tab.push_back(reg_row(REG_PITCH_UPPER, 32'h00007FFF));
        dir_tab.push_back(cmd_row(MODE_SET, 32767, -32768, '0, '0, '0, 1'b1, 32767, -32768));
        dir_tab.push_back(cmd_row(MODE_YAW_ADD, 32767, 0, '0, '0, '0, 1'b1, 32767, -32768));
        dir_tab.push_back(cmd_row(MODE_PITCH_ADD, 0, -32768, '0, '0, '0, 1'b1, 32767, -32768));
        dir_tab.push_back(cmd_row(MODE_YAW_ADD, -1, 0, '0, '0, '0, 1'b1, 32766, -32768));
        dir_tab.push_back(reg_row(REG_BASE_X, 32'h7FFFFFFF));
        dir_tab.push_back(reg_row(REG_BASE_Y, 32'h80000000));
        dir_tab.push_back(reg_row(REG_BASE_Z, 32'h80000000));
        dir_tab.push_back(cmd_row(MODE_AIM, 0, 0, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                  1'b0, 0, 0));
        // target exactly on the pivot
        dir_tab.push_back(cmd_row(MODE_AIM, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h8000999A,
                                  1'b1, 0, 0));
        dir_tab.push_back(cmd_row(MODE_AIM, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h8000999A,
                                  1'b0, 0, 0));
        // inverted limits
        dir_tab.push_back(reg_row(REG_YAW_LOWER, 32'd100));
        dir_tab.push_back(reg_row(REG_YAW_UPPER, 32'hFFFFFF9C));
        dir_tab.push_back(reg_row(REG_PITCH_LOWER, 32'd200));
        dir_tab.push_back(reg_row(REG_PITCH_UPPER, 32'hFFFFFF38));
        dir_tab.push_back(cmd_row(MODE_SET, 0, 0, '0, '0, '0, 1'b1, -100, -200));
        dir_tab.push_back(cmd_row(MODE_YAW_ADD, 5000, 0, '0, '0, '0, 1'b1, -100, -200));
        dir_tab.push_back(cmd_row(MODE_AIM, 0, 0, '0, '0, '0, 1'b1, -100, -200));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct  = 35;
        sink_idle_pct = 51;
        foreach (dir_tab[k])
        begin
            if (dir_tab[k].is_reg)
            begin
                drain();
                write_reg(dir_tab[k].reg_idx, dir_tab[k].reg_val);
            end
            else
            begin
                push_cmd(dir_tab[k].c, dir_tab[k].typed, dir_tab[k].fixed);
            end
        end

        for (ph = 0; ph < 4; ph++)
        begin
            drain();
            bx  = $urandom;
            by  = $urandom;
            bz  = $urandom;
            ylo = 32'(-8579);
            yhi = 32'(8579);
            plo = 32'(-4289);
            phi = 32'(4289);
            case (ph)
                1:
                begin
                    bx  = 32'h7FFFFFFF;
                    by  = 32'h80000000;
                    bz  = 32'h7FFFFFFF;
                    ylo = 32'hFFFF8000;
                    yhi = 32'h00007FFF;
                    plo = 32'hFFFF8000;
                    phi = 32'h00007FFF;
                end
                2:
                begin
                    bx  = 32'h80000000;
                    by  = 32'h7FFFFFFF;
                    bz  = 32'h80000000;
                    ylo = 32'(-25736);
                    yhi = 32'(25736);
                    plo = 32'(-25736);
                    phi = 32'(25736);
                end
                3:
                begin
                    a = int'($urandom_range(51472)) - 25736;
                    b = int'($urandom_range(51472)) - 25736;
                    if ((a > b) == ($urandom_range(3) != 0))
                    begin
                        t = a;
                        a = b;
                        b = t;
                    end
                    ylo = 32'(a);
                    yhi = 32'(b);
                    a = int'($urandom_range(51472)) - 25736;
                    b = int'($urandom_range(51472)) - 25736;
                    if ((a > b) == ($urandom_range(3) != 0))
                    begin
                        t = a;
                        a = b;
                        b = t;
                    end
                    plo = 32'(a);
                    phi = 32'(b);
                end
                default:
                begin
                end
            endcase
            write_reg(REG_BASE_X, bx);
            write_reg(REG_BASE_Y, by);
            write_reg(REG_BASE_Z, bz);
            write_reg(REG_YAW_LOWER, ylo);
            write_reg(REG_YAW_UPPER, yhi);
            write_reg(REG_PITCH_LOWER, plo);
            write_reg(REG_PITCH_UPPER, phi);

            src_idle_pct  = (ph == 0) ? 35 : (ph == 1) ? 51 : 0;
            sink_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 35 : 0;
            if (ph == 1)
            begin
                hold_cycles = 300;
            end
            repeat (PHASE_ITEMS) push_cmd(rand_cmd(), 1'b0, '0);
        end

        drain();
        repeat (60) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ptal_pkg.sv
hdl/ptal_if.sv
hdl/ptal_regs.sv
hdl/ptal_cordic.sv
hdl/ptal_seq.sv
hdl/pan_tilt_aim_limiter.sv
hdl/ptal_checker.sv
bench/pan_tilt_aim_limiter_tb.sv
